[src/towm_pkg.sv]
// ----------------------------------------------------------------------------
// Three-wheel omni mixer package
// Shared beat types, field widths, register indexes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package towm_pkg;

    localparam int VEL_W       = 16;
    localparam int RADIUS_W    = 16;
    localparam int LIM_W       = 15;
    localparam int BITS_W      = 4;
    localparam int POL_W       = 3;
    localparam int DUTY_W      = 14;
    localparam int DRIVE_W     = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int SPEED_W     = 36;
    localparam int ROT_W       = 33;
    localparam int KY_W        = 34;
    localparam int MAG_W       = 31;
    localparam int PROD_W      = MAG_W + DUTY_W;
    localparam int NUM_W       = PROD_W + 1;
    localparam int QUOT_SHIFT  = 16;
    localparam int REM_W       = LIM_W + 1;

    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = DUTY_W / STEPS_PER_STAGE;
    localparam int PRE_STAGES      = 5;
    localparam int NUM_STAGES      = PRE_STAGES + DIV_STAGES;

    localparam logic [17:0]       HALF_SQRT3_Q16 = 18'd56756;
    localparam logic [MAG_W-1:0]  STOP_BAND      = 31'd26843;
    localparam logic [BITS_W-1:0] MAX_DUTY_BITS  = 4'd14;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_BIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 2'd3;

    localparam logic [DRIVE_W-1:0] DRIVE_STOP = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_IN1  = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_IN2  = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST  = 16'd6554;
    localparam logic [LIM_W-1:0]    MAX_SPD_RST = 15'd4096;
    localparam logic [BITS_W-1:0]   DUTY_BITS_RST = 4'd10;
    localparam logic [POL_W-1:0]    POLARITY_RST  = 3'd0;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] yaw_rate;
    } t_cmd;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty_a;
        logic [DRIVE_W-1:0] drive_a;
        logic [DUTY_W-1:0]  duty_b;
        logic [DRIVE_W-1:0] drive_b;
        logic [DUTY_W-1:0]  duty_c;
        logic [DRIVE_W-1:0] drive_c;
    } t_drive;

    typedef struct packed {
        logic [LIM_W-1:0]  lim;
        logic [DUTY_W-1:0] full;
        logic              reversed;
    } t_lane_cfg;

endpackage

`default_nettype wire

[src/towm_lane.sv]
// ----------------------------------------------------------------------------
// Wheel lane
// Clamps one wheel speed, decides stop and direction, scales the magnitude
// to duty and divides by the speed limit two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module towm_lane (
    input  wire logic                                      i_clk,
    input  wire logic [towm_pkg::NUM_STAGES-1:0]           i_en,
    input  wire logic signed [towm_pkg::SPEED_W-1:0]       i_speed,
    input  wire towm_pkg::t_lane_cfg                       i_cfg,
    output logic [towm_pkg::DUTY_W-1:0]                    o_duty,
    output logic [towm_pkg::DRIVE_W-1:0]                   o_drive
);

    localparam int SW = towm_pkg::SPEED_W;
    localparam int MW = towm_pkg::MAG_W;
    localparam int DW = towm_pkg::DUTY_W;
    localparam int RW = towm_pkg::REM_W;
    localparam int LW = towm_pkg::LIM_W;
    localparam int ND = towm_pkg::DIV_STAGES;
    localparam int NP = towm_pkg::PRE_STAGES;
    localparam int QUOT_SHIFT_L = towm_pkg::QUOT_SHIFT;

    logic signed [SW-1:0] r_s2_speed;

    logic [MW-1:0] r_s3_mag;
    logic          r_s3_stop;
    logic          r_s3_fwd;

    logic [towm_pkg::PROD_W-1:0] r_s4_prod;
    logic                        r_s4_stop;
    logic                        r_s4_fwd;

    logic [RW-1:0] r_s5_rem;
    logic [DW-1:0] r_s5_word;
    logic          r_s5_stop;
    logic          r_s5_fwd;

    logic [RW-1:0] r_dv_rem  [ND];
    logic [DW-1:0] r_dv_word [ND];
    logic          r_dv_stop [ND];
    logic          r_dv_fwd  [ND];

    logic [RW-1:0] n_dv_rem  [ND];
    logic [DW-1:0] n_dv_word [ND];

    logic [MW-1:0]               bound;
    logic [SW-1:0]               abs_speed;
    logic [MW-1:0]               n_mag;
    logic                        n_neg;
    logic [towm_pkg::NUM_W-1:0]  num;
    logic [towm_pkg::NUM_W-1:0]  half_bound;
    logic [towm_pkg::NUM_W-QUOT_SHIFT_L-1:0] num_q;

    always_comb begin
        bound     = {i_cfg.lim, QUOT_SHIFT_L'(0)};
        n_neg     = r_s2_speed[SW-1];
        abs_speed = n_neg ? SW'(-r_s2_speed) : SW'(r_s2_speed);
        if (abs_speed > SW'(bound)) begin
            n_mag = bound;
        end else begin
            n_mag = abs_speed[MW-1:0];
        end
    end

    always_comb begin
        half_bound = towm_pkg::NUM_W'({i_cfg.lim, (QUOT_SHIFT_L - 1)'(0)});
        num        = towm_pkg::NUM_W'(r_s4_prod) + half_bound;
        num_q      = num[towm_pkg::NUM_W-1:QUOT_SHIFT_L];
    end

    always_comb begin
        logic [RW-1:0] rem;
        logic [DW-1:0] word;
        logic [RW-1:0] trial;
        for (int j = 0; j < ND; j++) begin
            if (j == 0) begin
                rem  = r_s5_rem;
                word = r_s5_word;
            end else begin
                rem  = r_dv_rem[(j == 0) ? 0 : j - 1];
                word = r_dv_word[(j == 0) ? 0 : j - 1];
            end
            for (int s = 0; s < towm_pkg::STEPS_PER_STAGE; s++) begin
                trial = {rem[LW-1:0], word[DW-1]};
                if (trial >= RW'(i_cfg.lim)) begin
                    rem  = trial - RW'(i_cfg.lim);
                    word = {word[DW-2:0], 1'b1};
                end else begin
                    rem  = trial;
                    word = {word[DW-2:0], 1'b0};
                end
            end
            n_dv_rem[j]  = rem;
            n_dv_word[j] = word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s2_speed <= i_speed;
        end
        if (i_en[2]) begin
            r_s3_mag  <= n_mag;
            r_s3_stop <= (n_mag <= towm_pkg::STOP_BAND);
            r_s3_fwd  <= (!n_neg) ^ i_cfg.reversed;
        end
        if (i_en[3]) begin
            r_s4_prod <= towm_pkg::PROD_W'(r_s3_mag) * towm_pkg::PROD_W'(i_cfg.full);
            r_s4_stop <= r_s3_stop;
            r_s4_fwd  <= r_s3_fwd;
        end
        if (i_en[4]) begin
            r_s5_rem  <= num_q[$bits(num_q)-1:DW];
            r_s5_word <= num_q[DW-1:0];
            r_s5_stop <= r_s4_stop;
            r_s5_fwd  <= r_s4_fwd;
        end
        for (int j = 0; j < ND; j++) begin
            if (i_en[NP + j]) begin
                r_dv_rem[j]  <= n_dv_rem[j];
                r_dv_word[j] <= n_dv_word[j];
                r_dv_stop[j] <= (j == 0) ? r_s5_stop : r_dv_stop[(j == 0) ? 0 : j - 1];
                r_dv_fwd[j]  <= (j == 0) ? r_s5_fwd  : r_dv_fwd[(j == 0) ? 0 : j - 1];
            end
        end
    end

    always_comb begin
        if (r_dv_stop[ND-1]) begin
            o_duty  = '0;
            o_drive = towm_pkg::DRIVE_STOP;
        end else begin
            o_duty  = r_dv_word[ND-1];
            o_drive = r_dv_fwd[ND-1] ? towm_pkg::DRIVE_IN1 : towm_pkg::DRIVE_IN2;
        end
    end

endmodule

`default_nettype wire

[src/three_wheel_omni_motor_mixer.sv]
// ----------------------------------------------------------------------------
// Three-wheel omni motor mixer
// Converts a body velocity command into duty and direction for three wheels.
// ----------------------------------------------------------------------------
// Each beat on the command channel produces exactly one beat of wheel drive.
// The datapath is a twelve-stage pipeline with one valid bit per stage, so a
// new command can be taken in every cycle while the output is not held off;
// the final duty division by the speed limit takes seven of those stages at
// two quotient bits each. Back-pressure only halts stages that hold data, so
// empty stages keep filling while a result waits. Configuration must only be
// written while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module three_wheel_omni_motor_mixer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [towm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [towm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire towm_pkg::t_cmd                      i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output towm_pkg::t_drive                         o_out_data
);

    localparam int NS = towm_pkg::NUM_STAGES;
    localparam int SW = towm_pkg::SPEED_W;

    logic [towm_pkg::RADIUS_W-1:0] r_radius;
    logic [towm_pkg::LIM_W-1:0]    r_max_spd;
    logic [towm_pkg::BITS_W-1:0]   r_duty_bits;
    logic [towm_pkg::POL_W-1:0]    r_polarity;

    logic [NS-1:0] r_valid;
    logic [NS-1:0] stage_rdy;

    logic signed [towm_pkg::VEL_W-1:0] r_s1_vx;
    logic signed [towm_pkg::ROT_W-1:0] r_s1_rot;
    logic signed [towm_pkg::KY_W-1:0]  r_s1_ky;

    logic [towm_pkg::LIM_W-1:0]  lim;
    logic [towm_pkg::BITS_W-1:0] bits_eff;
    logic [towm_pkg::DUTY_W:0]   pow2;
    logic [towm_pkg::DUTY_W-1:0] full;

    logic signed [SW-1:0] x_full;
    logic signed [SW-1:0] x_half;
    logic signed [SW-1:0] rot_ext;
    logic signed [SW-1:0] ky_ext;
    logic signed [SW-1:0] speed_a;
    logic signed [SW-1:0] speed_b;
    logic signed [SW-1:0] speed_c;

    towm_pkg::t_lane_cfg cfg_a;
    towm_pkg::t_lane_cfg cfg_b;
    towm_pkg::t_lane_cfg cfg_c;

    logic [towm_pkg::DUTY_W-1:0]  duty_a;
    logic [towm_pkg::DUTY_W-1:0]  duty_b;
    logic [towm_pkg::DUTY_W-1:0]  duty_c;
    logic [towm_pkg::DRIVE_W-1:0] drive_a;
    logic [towm_pkg::DRIVE_W-1:0] drive_b;
    logic [towm_pkg::DRIVE_W-1:0] drive_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= towm_pkg::RADIUS_RST;
            r_max_spd   <= towm_pkg::MAX_SPD_RST;
            r_duty_bits <= towm_pkg::DUTY_BITS_RST;
            r_polarity  <= towm_pkg::POLARITY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                towm_pkg::CFG_RADIUS:   r_radius    <= i_cfg_data[towm_pkg::RADIUS_W-1:0];
                towm_pkg::CFG_MAX_SPD:  r_max_spd   <= i_cfg_data[towm_pkg::LIM_W-1:0];
                towm_pkg::CFG_DUTY_BIT: r_duty_bits <= i_cfg_data[towm_pkg::BITS_W-1:0];
                towm_pkg::CFG_POLARITY: r_polarity  <= i_cfg_data[towm_pkg::POL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lim = (r_max_spd == '0) ? towm_pkg::LIM_W'(1) : r_max_spd;
        if (r_duty_bits == '0) begin
            bits_eff = towm_pkg::BITS_W'(1);
        end else if (r_duty_bits > towm_pkg::MAX_DUTY_BITS) begin
            bits_eff = towm_pkg::MAX_DUTY_BITS;
        end else begin
            bits_eff = r_duty_bits;
        end
        pow2 = (towm_pkg::DUTY_W + 1)'(1) << bits_eff;
        full = towm_pkg::DUTY_W'(pow2 - (towm_pkg::DUTY_W + 1)'(1));
        cfg_a = '{lim: lim, full: full, reversed: r_polarity[0]};
        cfg_b = '{lim: lim, full: full, reversed: r_polarity[1]};
        cfg_c = '{lim: lim, full: full, reversed: r_polarity[2]};
    end

    always_comb begin
        stage_rdy[NS-1] = !r_valid[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_rdy[k] = !r_valid[k] || stage_rdy[k+1];
        end
    end

    assign o_in_ready  = stage_rdy[0];
    assign o_out_valid = r_valid[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stage_rdy[k]) begin
                    r_valid[k] <= (k == 0) ? i_in_valid : r_valid[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r_s1_vx  <= i_in_data.vel_x;
            r_s1_rot <= towm_pkg::ROT_W'($signed({1'b0, r_radius}))
                        * towm_pkg::ROT_W'(i_in_data.yaw_rate);
            r_s1_ky  <= towm_pkg::KY_W'(i_in_data.vel_y)
                        * towm_pkg::KY_W'($signed(towm_pkg::HALF_SQRT3_Q16));
        end
    end

    always_comb begin
        x_full  = SW'(r_s1_vx) <<< 16;
        x_half  = SW'(r_s1_vx) <<< 15;
        rot_ext = SW'(r_s1_rot);
        ky_ext  = SW'(r_s1_ky);
        speed_a = x_full + rot_ext;
        speed_b = rot_ext - x_half - ky_ext;
        speed_c = rot_ext - x_half + ky_ext;
    end

    towm_lane u_lane_a (
        .i_clk   (i_clk),
        .i_en    (stage_rdy),
        .i_speed (speed_a),
        .i_cfg   (cfg_a),
        .o_duty  (duty_a),
        .o_drive (drive_a)
    );

    towm_lane u_lane_b (
        .i_clk   (i_clk),
        .i_en    (stage_rdy),
        .i_speed (speed_b),
        .i_cfg   (cfg_b),
        .o_duty  (duty_b),
        .o_drive (drive_b)
    );

    towm_lane u_lane_c (
        .i_clk   (i_clk),
        .i_en    (stage_rdy),
        .i_speed (speed_c),
        .i_cfg   (cfg_c),
        .o_duty  (duty_c),
        .o_drive (drive_c)
    );

    assign o_out_data = '{duty_a: duty_a, drive_a: drive_a,
                          duty_b: duty_b, drive_b: drive_b,
                          duty_c: duty_c, drive_c: drive_c};

endmodule

`default_nettype wire

[test/towm_checker.sv]
// ----------------------------------------------------------------------------
// Omni mixer drive checker
// Follows the configuration port and the command channel, works out the wheel
// drive that each accepted command must give, and compares every drive beat
// leaving the block, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module towm_checker
    import towm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_cmd_valid,
    input  logic                  i_cmd_ready,
    input  t_cmd                  i_cmd,
    input  logic                  i_drv_valid,
    input  logic                  i_drv_ready,
    input  t_drive                i_drv,
    output int                    o_mismatches,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [RADIUS_W-1:0] radius;
    logic [LIM_W-1:0]    speed_limit;
    logic [BITS_W-1:0]   duty_bits;
    logic [POL_W-1:0]    reversed_mask;
    t_drive              drive_queue[$];

    function automatic logic [DUTY_W+DRIVE_W-1:0] wheel_drive(input longint speed,
                                                             input logic rev);
        longint lim;
        longint bound;
        longint full;
        longint clamped;
        longint mag;
        longint duty;
        int     width;
        lim = (speed_limit == '0) ? 64'sd1 : longint'(speed_limit);
        bound = lim * 65536;
        width = int'(duty_bits);
        if (width < 1) begin
            width = 1;
        end
        if (width > int'(MAX_DUTY_BITS)) begin
            width = int'(MAX_DUTY_BITS);
        end
        full = (64'sd1 <<< width) - 1;
        clamped = speed;
        if (clamped > bound) begin
            clamped = bound;
        end
        if (clamped < -bound) begin
            clamped = -bound;
        end
        mag = (clamped < 0) ? -clamped : clamped;
        if (mag <= longint'(STOP_BAND)) begin
            return {{DUTY_W{1'b0}}, DRIVE_STOP};
        end
        duty = (mag * full + bound / 2) / bound;
        return {duty[DUTY_W-1:0], (((clamped > 0) ^ rev) ? DRIVE_IN1 : DRIVE_IN2)};
    endfunction

    function automatic t_drive mix_wheels(input t_cmd c);
        longint vx;
        longint vy;
        longint rot;
        longint ky;
        t_drive r;
        vx = longint'(c.vel_x);
        vy = longint'(c.vel_y);
        rot = longint'(radius) * longint'(c.yaw_rate);
        ky = vy * longint'(HALF_SQRT3_Q16);
        {r.duty_a, r.drive_a} = wheel_drive(vx * 65536 + rot, reversed_mask[0]);
        {r.duty_b, r.drive_b} = wheel_drive(-vx * 32768 - ky + rot, reversed_mask[1]);
        {r.duty_c, r.drive_c} = wheel_drive(-vx * 32768 + ky + rot, reversed_mask[2]);
        return r;
    endfunction

    initial begin
        o_mismatches = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin : watch
        t_drive want;
        if (!i_rst_n) begin
            radius = RADIUS_RST;
            speed_limit = MAX_SPD_RST;
            duty_bits = DUTY_BITS_RST;
            reversed_mask = POLARITY_RST;
            drive_queue.delete();
        end else begin
            if (i_drv_valid && i_drv_ready) begin
                if (drive_queue.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("%0t: drive beat with none outstanding: %h", $realtime, i_drv);
                    end
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = drive_queue.pop_front();
                    if (want.duty_a !== i_drv.duty_a || want.drive_a !== i_drv.drive_a ||
                        want.duty_b !== i_drv.duty_b || want.drive_b !== i_drv.drive_b ||
                        want.duty_c !== i_drv.duty_c || want.drive_c !== i_drv.drive_c) begin
                        if (o_mismatches < 10) begin
                            $display("%0t: drive mismatch: expected A %0d/%0d B %0d/%0d C %0d/%0d, got A %0d/%0d B %0d/%0d C %0d/%0d",
                                     $realtime,
                                     want.duty_a, want.drive_a, want.duty_b, want.drive_b,
                                     want.duty_c, want.drive_c,
                                     i_drv.duty_a, i_drv.drive_a, i_drv.duty_b, i_drv.drive_b,
                                     i_drv.duty_c, i_drv.drive_c);
                        end
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                drive_queue.push_back(mix_wheels(i_cmd));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS: begin
                        radius = i_cfg_data[RADIUS_W-1:0];
                    end
                    CFG_MAX_SPD: begin
                        speed_limit = i_cfg_data[LIM_W-1:0];
                    end
                    CFG_DUTY_BIT: begin
                        duty_bits = i_cfg_data[BITS_W-1:0];
                    end
                    CFG_POLARITY: begin
                        reversed_mask = i_cfg_data[POL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = drive_queue.size();
    end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Omni mixer testbench
// Drives body velocity commands into the mixer under several register
// settings and handshake idling patterns, including a long output hold-off,
// and reports the verdict given by the drive checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import towm_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 126;
    localparam int DRAIN_CYCLES    = 30;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_cmd                  i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_drive                o_out_data;

    int   mismatches;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   stall_cycles;
    int   cur_limit;
    logic hold_go;

    three_wheel_omni_motor_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    towm_checker drive_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_valid  (i_in_valid),
        .i_cmd_ready  (o_in_ready),
        .i_cmd        (i_in_data),
        .i_drv_valid  (o_out_valid),
        .i_drv_ready  (i_out_ready),
        .i_drv        (o_out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin : receiver
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_cmd cmd(input int vx, input int vy, input int w);
        t_cmd c;
        c.vel_x = vx[VEL_W-1:0];
        c.vel_y = vy[VEL_W-1:0];
        c.yaw_rate = w[VEL_W-1:0];
        return c;
    endfunction

    function automatic int pick_vel(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 0;
        end
        if (r == 1) begin
            return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        end
        if (r < 5) begin
            return int'($urandom_range(0, 65535)) - 32768;
        end
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send(input t_cmd c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= c;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic setup_phase(input int phase);
        int rad;
        int lim;
        int res;
        int pol;
        case (phase)
            1: begin
                rad = 1;
                lim = 1;
                res = 1;
                pol = 7;
            end
            2: begin
                rad = 65535;
                lim = 32767;
                res = 14;
                pol = 5;
            end
            3: begin
                rad = 0;
                lim = 0;
                res = 0;
                pol = 2;
            end
            4: begin
                rad = 16'hFFFF;
                lim = 16'hFFFF;
                res = 16'hFFFF;
                pol = 16'hFFF8;
            end
            default: begin
                rad = $urandom_range(0, 65535);
                lim = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8192)
                                                  : $urandom_range(0, 32767);
                res = $urandom_range(0, 15);
                pol = $urandom_range(0, 7);
            end
        endcase
        write_cfg(CFG_RADIUS, rad);
        write_cfg(CFG_MAX_SPD, lim);
        write_cfg(CFG_DUTY_BIT, res);
        write_cfg(CFG_POLARITY, pol);
        i_cfg_we <= 1'b0;
        cur_limit = lim & 16'h7FFF;
    endtask

    initial begin : stimulus
        int span_y;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_RADIUS;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        tx_idle_pct = 36;
        rx_idle_pct = 58;
        hold_go = 1'b0;
        cur_limit = int'(MAX_SPD_RST);
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(cmd(0, 0, 0));
        send(cmd(32767, 0, 0));
        send(cmd(-32768, 0, 0));
        send(cmd(0, 32767, 0));
        send(cmd(0, -32768, 0));
        send(cmd(0, 0, 32767));
        send(cmd(0, 0, -32768));
        send(cmd(32767, 32767, 32767));
        send(cmd(-32768, -32768, -32768));
        send(cmd(0, 0, 4));
        send(cmd(0, 0, 5));
        send(cmd(0, 0, -4));
        send(cmd(0, 0, -5));
        send(cmd(1, 0, 0));
        send(cmd(3, 0, 0));
        send(cmd(0, 1, 0));
        send(cmd(1, 0, -10));
        send(cmd(2048, 0, 0));
        send(cmd(4096, 0, 0));
        send(cmd(-4096, 0, 0));
        send(cmd(-2048, 2365, 0));

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            if (phase != 0) begin
                setup_phase(phase);
            end
            tx_idle_pct = (phase < 3) ? 36 : ((phase < 6) ? 58 : 0);
            rx_idle_pct = (phase < 3) ? 58 : ((phase < 6) ? 36 : 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 2 && n == 30) begin
                    hold_go = 1'b1;
                end
                span_y = ($urandom_range(0, 1) != 0) ? 8 : cur_limit;
                send(cmd(pick_vel(cur_limit), pick_vel(cur_limit), pick_vel(span_y)));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
